@@ src/voxel_grid_bucket_sorter_macros.svh @@
// Assertion macros shared by the voxel grid bucket sorter.
`ifndef VOXEL_GRID_BUCKET_SORTER_MACROS_SVH
`define VOXEL_GRID_BUCKET_SORTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define VGBS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define VGBS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/vgbs_pkg.sv @@
// Shared types, constants and functions of the voxel grid bucket sorter.
`timescale 1ns / 1ps
package vgbs_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned BS_W    = 31;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned BCNT_W  = 11;
  localparam int unsigned PROD_W  = 2 * COORD_W;

  localparam logic [KEY_W-1:0] HASH_ADD         = 64'h0000_0000_9e37_79b9;
  localparam logic [BS_W-1:0]  BLOCK_SIZE_RESET = 31'd19661;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shffff_ffff_8000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] dividend;
    logic [BS_W-1:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [KEY_W-1:0] hash_step(input logic [KEY_W-1:0] h,
                                                 input logic signed [COORD_W-1:0] v);
    logic [KEY_W-1:0] vx;
    vx = {{(KEY_W-COORD_W){v[COORD_W-1]}}, v};
    return h ^ (vx + HASH_ADD + (h << 6) + (h >> 2));
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] p);
    logic signed [COORD_W-1:0] r;
    if (p > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (p < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = p[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/vgbs_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module vgbs_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [W-1:0]             wdata_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/vgbs_div.sv @@
// Bit-serial floor divider of a signed coordinate by the unsigned voxel size.
`timescale 1ns / 1ps
module vgbs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vgbs_pkg::div_req_t  req_i,
  output vgbs_pkg::div_rsp_t  rsp_o
);
  import vgbs_pkg::*;

  localparam int unsigned STEP_W = $clog2(COORD_W + 1);

  logic [STEP_W-1:0]  step_q, step_d;
  logic               fin_q, fin_d;
  logic [COORD_W-1:0] mag_q, mag_d, rem_q, rem_d;
  logic [BS_W-1:0]    dvs_q, dvs_d;
  logic               neg_q, neg_d;
  logic [COORD_W-1:0] rem_sh;
  logic [COORD_W:0]   diff;
  logic [COORD_W:0]   qneg;

  always_comb begin
    step_d = step_q;
    fin_d  = 1'b0;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[COORD_W-2:0], mag_q[COORD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (req_i.start) begin
      neg_d  = req_i.dividend[COORD_W-1];
      mag_d  = req_i.dividend[COORD_W-1] ? (COORD_W'(0) - COORD_W'(req_i.dividend))
                                         : COORD_W'(req_i.dividend);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      step_d = STEP_W'(COORD_W);
    end else if (step_q != '0) begin
      if (!diff[COORD_W]) begin
        rem_d = diff[COORD_W-1:0];
        mag_d = {mag_q[COORD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        mag_d = {mag_q[COORD_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      fin_d  = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      fin_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign qneg = (COORD_W+1)'(0) - {1'b0, mag_q} - {{COORD_W{1'b0}}, |rem_q};

  assign rsp_o.done = fin_q;
  assign rsp_o.quot = neg_q ? qneg[COORD_W-1:0] : mag_q;

endmodule

@@ src/voxel_grid_bucket_sorter.sv @@
// Top level of the voxel grid bucket sorter: sequencer, point and sorted-entry memories.
//
// Usage: a command transaction is taken at a rising edge with start high and busy low.
// opcode 0 stores one point and gives no result. last_point on a load starts the
// build: for each point one point memory read and the shared 32-step divider once per
// axis, then an insertion walk that reads and rewrites each displaced entry, then
// two passes of a read and a write per point group the runs. busy stays high for
// the whole build.
// opcode 1 reads one sorted position. Out of range or before a build: result in the
// cycle after the transaction. Otherwise the read does two entry memory reads, one point
// memory read, three divider runs and three multiply/saturate steps.
// The result sits on the result ports for one cycle with res_valid_o high; the
// receiver cannot stall it. cfg_ready_o is always high; write block_size only while
// idle. Reset clears the point count and build state and sets block_size to 19661;
// memory contents are undefined until written, no clearing pass.
`timescale 1ns / 1ps
`include "voxel_grid_bucket_sorter_macros.svh"
module voxel_grid_bucket_sorter #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode_i,
  input  logic signed [vgbs_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [vgbs_pkg::COORD_W-1:0]   coord_y_i,
  input  logic signed [vgbs_pkg::COORD_W-1:0]   coord_z_i,
  input  logic                                  last_point_i,
  input  logic [vgbs_pkg::POS_W-1:0]            position_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [vgbs_pkg::BS_W-1:0]             cfg_data_i,
  output logic                                  res_valid_o,
  output logic                                  status_o,
  output logic [vgbs_pkg::POS_W-1:0]            point_index_o,
  output logic [vgbs_pkg::KEY_W-1:0]            voxel_key_o,
  output logic [vgbs_pkg::POS_W-1:0]            block_offset_o,
  output logic [vgbs_pkg::BCNT_W-1:0]           block_count_o,
  output logic signed [vgbs_pkg::COORD_W-1:0]   corner_x_o,
  output logic signed [vgbs_pkg::COORD_W-1:0]   corner_y_o,
  output logic signed [vgbs_pkg::COORD_W-1:0]   corner_z_o,
  output logic                                  block_start_o
);
  import vgbs_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned CMPW = (POS_W > CW) ? POS_W : CW;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_PT_RD    = 16'h0002,
    ST_CAP      = 16'h0004,
    ST_DIV_GO   = 16'h0008,
    ST_DIV_WAIT = 16'h0010,
    ST_INS_RD   = 16'h0020,
    ST_INS_CMP  = 16'h0040,
    ST_FW_RD    = 16'h0080,
    ST_FW_WR    = 16'h0100,
    ST_BW_RD    = 16'h0200,
    ST_BW_WR    = 16'h0400,
    ST_RD1      = 16'h0800,
    ST_RD2      = 16'h1000,
    ST_MUL      = 16'h2000,
    ST_SAT      = 16'h4000,
    ST_OUT      = 16'h8000
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AW-1:0]    pt;
    logic [AW-1:0]    rs;
    logic [AW:0]      len;
  } entry_t;

  localparam int unsigned PW = $bits(point_t);
  localparam int unsigned EW = $bits(entry_t);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          built_q, built_d;
  logic [BS_W-1:0] bs_q, bs_d;
  logic          rmode_q, rmode_d;
  logic [1:0]    ax_q, ax_d;

  logic [AW-1:0]  pt_q, pt_d;
  logic [AW-1:0]  wk_q, wk_d;
  logic signed [COORD_W-1:0] coord_q [3];
  logic signed [COORD_W-1:0] coord_d [3];
  logic signed [COORD_W-1:0] vox_q [3];
  logic signed [COORD_W-1:0] vox_d [3];
  logic signed [COORD_W-1:0] corner_q [3];
  logic signed [COORD_W-1:0] corner_d [3];
  logic [KEY_W-1:0] hash_q, hash_d;
  logic [KEY_W-1:0] pkey_q, pkey_d;
  logic [AW-1:0]    rstart_q, rstart_d;
  logic [AW-1:0]    prs_q, prs_d;
  logic [AW-1:0]    end_q, end_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic             rstat_q, rstat_d;
  logic [AW-1:0]    rpt_q, rpt_d;
  logic [KEY_W-1:0] rkey_q, rkey_d;
  logic [AW-1:0]    rrs_q, rrs_d;
  logic [AW:0]      rlen_q, rlen_d;
  logic             rbs_q, rbs_d;

  logic           pa_we;
  logic [AW-1:0]  pa_addr;
  point_t         pa_wdata, pa_rd;
  logic           eb_we;
  logic [AW-1:0]  eb_addr;
  entry_t         eb_wdata, eb_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [BS_W-1:0] bs_eff;
  logic            accept;
  logic [CW-1:0]   base;
  logic            in_range;
  logic            last_pt;
  logic [AW-1:0]   st_now;
  logic [AW-1:0]   end_now;

  vgbs_ram #(.W(PW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pa_we),
    .addr_i  (pa_addr),
    .wdata_i (pa_wdata),
    .rdata_o (pa_rd)
  );

  vgbs_ram #(.W(EW), .DEPTH(MAX_POINTS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (eb_we),
    .addr_i  (eb_addr),
    .wdata_i (eb_wdata),
    .rdata_o (eb_rd)
  );

  vgbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign bs_eff   = (bs_q == '0) ? BS_W'(1) : bs_q;
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign base     = built_q ? '0 : cnt_q;
  assign in_range = CMPW'(position_i) < CMPW'(cnt_q);
  assign last_pt  = (CW'(pt_q) + CW'(1)) == cnt_q;

  assign div_req.start    = (state_q == ST_DIV_GO);
  assign div_req.dividend = coord_q[ax_q];
  assign div_req.divisor  = bs_eff;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    built_d  = built_q;
    bs_d     = bs_q;
    rmode_d  = rmode_q;
    ax_d     = ax_q;
    pt_d     = pt_q;
    wk_d     = wk_q;
    coord_d  = coord_q;
    vox_d    = vox_q;
    corner_d = corner_q;
    hash_d   = hash_q;
    pkey_d   = pkey_q;
    rstart_d = rstart_q;
    prs_d    = prs_q;
    end_d    = end_q;
    pos_d    = pos_q;
    prod_d   = prod_q;
    rstat_d  = rstat_q;
    rpt_d    = rpt_q;
    rkey_d   = rkey_q;
    rrs_d    = rrs_q;
    rlen_d   = rlen_q;
    rbs_d    = rbs_q;
    pa_we    = 1'b0;
    pa_addr  = '0;
    pa_wdata = {coord_x_i, coord_y_i, coord_z_i};
    eb_we    = 1'b0;
    eb_addr  = '0;
    eb_wdata = eb_rd;
    st_now   = (wk_q == '0 || eb_rd.key != pkey_q) ? wk_q : rstart_q;
    end_now  = ((CW'(wk_q) + CW'(1)) == cnt_q || eb_rd.rs != prs_q) ? wk_q : end_q;

    if (cfg_valid_i && cfg_ready_o) begin
      bs_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            built_d = 1'b0;
            cnt_d   = base;
            if (base < CW'(MAX_POINTS)) begin
              pa_we   = 1'b1;
              pa_addr = AW'(base);
              cnt_d   = base + CW'(1);
            end
            if (last_point_i) begin
              pt_d    = '0;
              rmode_d = 1'b0;
              state_d = ST_PT_RD;
            end
          end else begin
            if (!built_q || !in_range) begin
              rstat_d = 1'b1;
              state_d = ST_OUT;
            end else begin
              eb_addr = AW'(position_i);
              pos_d   = AW'(position_i);
              rmode_d = 1'b1;
              state_d = ST_RD1;
            end
          end
        end
      end
      ST_PT_RD: begin
        pa_addr = pt_q;
        state_d = ST_CAP;
      end
      ST_CAP: begin
        coord_d[0] = pa_rd.x;
        coord_d[1] = pa_rd.y;
        coord_d[2] = pa_rd.z;
        ax_d       = '0;
        hash_d     = '0;
        state_d    = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          vox_d[ax_q] = div_rsp.quot;
          hash_d      = hash_step(hash_q, div_rsp.quot);
          if (ax_q == 2'd2) begin
            ax_d = '0;
            if (rmode_q) begin
              state_d = ST_MUL;
            end else begin
              wk_d    = pt_q;
              state_d = ST_INS_RD;
            end
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_INS_RD: begin
        if (wk_q == '0) begin
          eb_we    = 1'b1;
          eb_addr  = '0;
          eb_wdata = '{key: hash_q, pt: pt_q, rs: '0, len: '0};
          if (last_pt) begin
            wk_d    = '0;
            state_d = ST_FW_RD;
          end else begin
            pt_d    = pt_q + AW'(1);
            state_d = ST_PT_RD;
          end
        end else begin
          eb_addr = wk_q - AW'(1);
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        eb_we   = 1'b1;
        eb_addr = wk_q;
        if (eb_rd.key > hash_q) begin
          eb_wdata = eb_rd;
          wk_d     = wk_q - AW'(1);
          state_d  = ST_INS_RD;
        end else begin
          eb_wdata = '{key: hash_q, pt: pt_q, rs: '0, len: '0};
          if (last_pt) begin
            wk_d    = '0;
            state_d = ST_FW_RD;
          end else begin
            pt_d    = pt_q + AW'(1);
            state_d = ST_PT_RD;
          end
        end
      end
      ST_FW_RD: begin
        eb_addr = wk_q;
        state_d = ST_FW_WR;
      end
      ST_FW_WR: begin
        eb_we       = 1'b1;
        eb_addr     = wk_q;
        eb_wdata    = eb_rd;
        eb_wdata.rs = st_now;
        rstart_d    = st_now;
        pkey_d      = eb_rd.key;
        if ((CW'(wk_q) + CW'(1)) == cnt_q) begin
          state_d = ST_BW_RD;
        end else begin
          wk_d    = wk_q + AW'(1);
          state_d = ST_FW_RD;
        end
      end
      ST_BW_RD: begin
        eb_addr = wk_q;
        state_d = ST_BW_WR;
      end
      ST_BW_WR: begin
        eb_we        = 1'b1;
        eb_addr      = wk_q;
        eb_wdata     = eb_rd;
        eb_wdata.len = {1'b0, end_now} - {1'b0, eb_rd.rs} + CW'(1);
        end_d        = end_now;
        prs_d        = eb_rd.rs;
        if (wk_q == '0) begin
          built_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          wk_d    = wk_q - AW'(1);
          state_d = ST_BW_RD;
        end
      end
      ST_RD1: begin
        rstat_d = 1'b0;
        rpt_d   = eb_rd.pt;
        rkey_d  = eb_rd.key;
        rrs_d   = eb_rd.rs;
        rlen_d  = eb_rd.len;
        eb_addr = eb_rd.rs;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        pa_addr = eb_rd.pt;
        rbs_d   = (rrs_q == pos_q);
        state_d = ST_CAP;
      end
      ST_MUL: begin
        prod_d  = vox_q[ax_q] * signed'({1'b0, bs_eff});
        state_d = ST_SAT;
      end
      ST_SAT: begin
        corner_d[ax_q] = sat32(prod_q);
        if (ax_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      built_q <= 1'b0;
      bs_q    <= BLOCK_SIZE_RESET;
      rmode_q <= 1'b0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      built_q <= built_d;
      bs_q    <= bs_d;
      rmode_q <= rmode_d;
      ax_q    <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q     <= pt_d;
    wk_q     <= wk_d;
    coord_q  <= coord_d;
    vox_q    <= vox_d;
    corner_q <= corner_d;
    hash_q   <= hash_d;
    pkey_q   <= pkey_d;
    rstart_q <= rstart_d;
    prs_q    <= prs_d;
    end_q    <= end_d;
    pos_q    <= pos_d;
    prod_q   <= prod_d;
    rstat_q  <= rstat_d;
    rpt_q    <= rpt_d;
    rkey_q   <= rkey_d;
    rrs_q    <= rrs_d;
    rlen_q   <= rlen_d;
    rbs_q    <= rbs_d;
  end

  assign res_valid_o    = (state_q == ST_OUT);
  assign status_o       = rstat_q;
  assign point_index_o  = rstat_q ? '0 : POS_W'(rpt_q);
  assign voxel_key_o    = rstat_q ? '0 : rkey_q;
  assign block_offset_o = rstat_q ? '0 : POS_W'(rrs_q);
  assign block_count_o  = rstat_q ? '0 : BCNT_W'(rlen_q);
  assign corner_x_o     = rstat_q ? '0 : corner_q[0];
  assign corner_y_o     = rstat_q ? '0 : corner_q[1];
  assign corner_z_o     = rstat_q ? '0 : corner_q[2];
  assign block_start_o  = rstat_q ? 1'b0 : rbs_q;

  `VGBS_ASSERT_NXT(a_strobe_single, res_valid_o, !res_valid_o, "result strobe longer than one cycle")
  `VGBS_ASSERT_NXT(a_read_holds_busy, accept && opcode_i == OP_READ, busy, "read did not raise busy")
  `VGBS_ASSERT_IMP(a_count_bound, 1'b1, cnt_q <= CW'(MAX_POINTS), "point count beyond capacity")

endmodule
